>>> src/tbi_pkg.sv
// shared types, constants and helpers of the table bilinear interpolator
// no dependencies; imported by every module of the block
package tbi_pkg;

  localparam int AXIS_DEPTH = 64;
  localparam int VALUE_W    = 32;
  localparam int IDX_W      = $clog2(AXIS_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int HALF_W     = IDX_W - 1;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_REG_W  = 7;
  localparam int GRP_W      = 8;
  localparam int NGRP       = AXIS_DEPTH / GRP_W;
  localparam int GCNT_W     = $clog2(GRP_W) + 1;
  localparam int MAG_W      = VALUE_W + 1;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int DIV_STEPS  = MAG_W;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [OP_W-1:0] {
    OP_WR_RHO  = 2'd0,
    OP_WR_TEMP = 2'd1,
    OP_WR_GRID = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_RHO_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COUNT = CFG_IDX_W'(1);
  localparam logic [CNT_REG_W-1:0] COUNT_RESET    = CNT_REG_W'(AXIS_DEPTH);

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    value_t           val;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    value_t           val;
  } grid_wr_t;

  typedef struct packed {
    value_t lo_val;
    value_t hi_val;
    logic   clamped;
    logic   sel_hi;
  } axis_rd_t;

  typedef struct packed {
    value_t g00;
    value_t g01;
    value_t g10;
    value_t g11;
  } grid_rd_t;

  typedef struct packed {
    value_t tq;
    value_t tlo;
    value_t thi;
    logic   to;
    logic   tsel;
    logic   ro;
    logic   last;
  } row_side_t;

  localparam int SIDE_W = $bits(row_side_t);

  typedef struct packed {
    logic [SIDE_W-4:0] pad;
    logic              ro;
    logic              to;
    logic              last;
  } res_side_t;

  // counts outside the usable range act as the nearest legal count
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_REG_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c < CNT_REG_W'(2)) r = CNT_W'(2);
    else if (c > CNT_REG_W'(AXIS_DEPTH)) r = CNT_W'(AXIS_DEPTH);
    else r = CNT_W'(c);
    return r;
  endfunction

endpackage

>>> src/tbi_axis.sv
// one axis: entry registers for the bracket search, even/odd banks for bracket reads
// depends on tbi_pkg
module tbi_axis import tbi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  value_t           q_i,
  input  logic [CNT_W-1:0] count_i,
  input  tbl_wr_t          wr_i,
  output logic [IDX_W-1:0] cell_o,
  output axis_rd_t         rd_o
);

  localparam int HALF_DEPTH = AXIS_DEPTH / 2;

  value_t axis_q [AXIS_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) axis_q[wr_i.idx] <= wr_i.val;
  end

  // stage 2: compare against every entry
  logic [AXIS_DEPTH-1:0] lt_d, gt_d, lt2_q, gt2_q;
  logic                  inc2_q, v2_q;
  logic [CNT_W-1:0]      n2_q;

  always_comb begin
    for (int i = 0; i < AXIS_DEPTH; i++) begin
      lt_d[i] = axis_q[i] < q_i;
      gt_d[i] = axis_q[i] > q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lt2_q  <= lt_d;
    gt2_q  <= gt_d;
    inc2_q <= axis_q[1] >= axis_q[0];
    n2_q   <= count_i;
  end

  // stage 3: inner hits in groups, range flags
  logic [AXIS_DEPTH-1:0] hit;
  logic [GCNT_W-1:0]     grp_d [NGRP];
  logic [GCNT_W-1:0]     grp3_q [NGRP];
  logic [IDX_W-1:0]      lidx;
  logic                  out3_d, endhi3_d, out3_q, endhi3_q, v3_q;
  logic [CNT_W-1:0]      n3_q;

  always_comb begin
    for (int i = 0; i < AXIS_DEPTH; i++) begin
      hit[i] = (i >= 1) && ((i + 1) < int'(n2_q)) && (inc2_q ? lt2_q[i] : !lt2_q[i]);
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int b = 0; b < GRP_W; b++) begin
        grp_d[g] = grp_d[g] + GCNT_W'(hit[g*GRP_W+b]);
      end
    end
    lidx = IDX_W'(n2_q - 1'b1);
    if (inc2_q) begin
      out3_d   = gt2_q[0] || lt2_q[lidx];
      endhi3_d = !gt2_q[0];
    end else begin
      out3_d   = lt2_q[0] || gt2_q[lidx];
      endhi3_d = !lt2_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    grp3_q   <= grp_d;
    out3_q   <= out3_d;
    endhi3_q <= endhi3_d;
    n3_q     <= n2_q;
  end

  // stage 4: lower bracket index
  logic [IDX_W-1:0] lo4_d, lo4_q;
  logic             out4_q, endhi4_q, v4_q;
  logic [CNT_W-1:0] n4_q;

  always_comb begin
    lo4_d = '0;
    for (int g = 0; g < NGRP; g++) lo4_d = lo4_d + IDX_W'(grp3_q[g]);
  end

  always_ff @(posedge clk_i) begin
    lo4_q    <= lo4_d;
    out4_q   <= out3_q;
    endhi4_q <= endhi3_q;
    n4_q     <= n3_q;
  end

  // stage 5: cell to read; a clamped value reads the end cell
  logic [IDX_W-1:0] cell_q;
  logic             out5_q, sel5_q, v5_q;

  always_ff @(posedge clk_i) begin
    cell_q <= out4_q ? (endhi4_q ? IDX_W'(n4_q - CNT_W'(2)) : '0) : lo4_q;
    out5_q <= out4_q;
    sel5_q <= endhi4_q;
  end

  assign cell_o = cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v2_q <= q_valid_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // bank writes follow the items to stage 5 so reads stay in order
  tbl_wr_t wr_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) wr_q[k] <= '0;
    end else begin
      wr_q[0] <= wr_i;
      for (int k = 1; k < 4; k++) wr_q[k] <= wr_q[k-1];
    end
  end

  value_t            even_mem [HALF_DEPTH];
  value_t            odd_mem  [HALF_DEPTH];
  value_t            even_q, odd_q;
  logic [HALF_W-1:0] ev_addr, od_addr;
  logic              par6_q, out6_q, sel6_q;

  assign od_addr = cell_q[IDX_W-1:1];
  assign ev_addr = cell_q[0] ? cell_q[IDX_W-1:1] + 1'b1 : cell_q[IDX_W-1:1];

  always_ff @(posedge clk_i) begin
    if (wr_q[3].en && !wr_q[3].idx[0]) even_mem[wr_q[3].idx[IDX_W-1:1]] <= wr_q[3].val;
    if (wr_q[3].en && wr_q[3].idx[0])  odd_mem[wr_q[3].idx[IDX_W-1:1]]  <= wr_q[3].val;
    if (v5_q) begin
      even_q <= even_mem[ev_addr];
      odd_q  <= odd_mem[od_addr];
    end
    par6_q <= cell_q[0];
    out6_q <= out5_q;
    sel6_q <= sel5_q;
  end

  assign rd_o.lo_val  = par6_q ? odd_q : even_q;
  assign rd_o.hi_val  = par6_q ? even_q : odd_q;
  assign rd_o.clamped = out6_q;
  assign rd_o.sel_hi  = sel6_q;

`ifndef NO_ASSERTIONS
  a_lo_in_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (CNT_W'(lo4_q) + CNT_W'(2)) <= n4_q)
    else $error("bracket index beyond the last cell");

  a_low_end_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && out5_q && !sel5_q) |-> (cell_q == '0))
    else $error("clamp to first entry does not read the first cell");
`endif

endmodule

>>> src/tbi_grid.sv
// grid store in four banks by row and column parity, one cell corner per bank
// depends on tbi_pkg
module tbi_grid import tbi_pkg::*; (
  input  logic             clk_i,
  input  grid_wr_t         wr_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] row_i,
  input  logic [IDX_W-1:0] col_i,
  output grid_rd_t         rd_o
);

  localparam int BANK_DEPTH = AXIS_DEPTH * AXIS_DEPTH / 4;

  logic [HALF_W-1:0] rh0, rh1, ch0, ch1;
  value_t            data_q [4];
  logic              rp_q, cp_q;

  // half address of the bracket row (column) that has a given parity
  assign rh1 = row_i[IDX_W-1:1];
  assign rh0 = row_i[0] ? row_i[IDX_W-1:1] + 1'b1 : row_i[IDX_W-1:1];
  assign ch1 = col_i[IDX_W-1:1];
  assign ch0 = col_i[0] ? col_i[IDX_W-1:1] + 1'b1 : col_i[IDX_W-1:1];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BT = 1'(b >> 1);
    localparam logic BC = 1'(b & 1);
    value_t              mem [BANK_DEPTH];
    logic [2*HALF_W-1:0] addr;

    assign addr = {(BT ? rh1 : rh0), (BC ? ch1 : ch0)};

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.row[0] == BT) && (wr_i.col[0] == BC)) begin
        mem[{wr_i.row[IDX_W-1:1], wr_i.col[IDX_W-1:1]}] <= wr_i.val;
      end
      if (rd_en_i) data_q[b] <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q <= row_i[0];
    cp_q <= col_i[0];
  end

  always_comb begin
    rd_o.g00 = rp_q ? (cp_q ? data_q[3] : data_q[2]) : (cp_q ? data_q[1] : data_q[0]);
    rd_o.g01 = rp_q ? (cp_q ? data_q[2] : data_q[3]) : (cp_q ? data_q[0] : data_q[1]);
    rd_o.g10 = rp_q ? (cp_q ? data_q[1] : data_q[0]) : (cp_q ? data_q[3] : data_q[2]);
    rd_o.g11 = rp_q ? (cp_q ? data_q[0] : data_q[1]) : (cp_q ? data_q[2] : data_q[3]);
  end

endmodule

>>> src/tbi_lerp.sv
// pipelined one-axis interpolation step: clamp, multiply, restoring divide, one bit a stage
// depends on tbi_pkg
module tbi_lerp import tbi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  value_t            v_i,
  input  value_t            lo_i,
  input  value_t            hi_i,
  input  value_t            f0_i,
  input  value_t            f1_i,
  input  logic              byp_i,
  input  value_t            byp_val_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              out_valid_o,
  output value_t            res_o,
  output logic [SIDE_W-1:0] side_o
);

  typedef struct packed {
    value_t             f0;
    logic               dneg;
    logic               zero;
    logic               byp;
    value_t             bval;
    logic [SIDE_W-1:0]  side;
    logic [MAG_W-1:0]   dmag;
  } ctx_t;

  localparam int NVLD = DIV_STEPS + 7;

  function automatic logic [PROD_W-1:0] div_step(input logic [PROD_W-1:0] w,
                                                 input logic [MAG_W-1:0]  d);
    logic [MAG_W:0]        r;
    logic [MAG_W:0]        s;
    logic [PROD_W-1:0]     n;
    r = w[PROD_W-1:MAG_W-1];
    s = r - {1'b0, d};
    if (r >= {1'b0, d}) n = {s[MAG_W-1:0], w[MAG_W-2:0], 1'b1};
    else n = {w[PROD_W-2:0], 1'b0};
    return n;
  endfunction

  logic [NVLD-1:0] vld_q;

  // stage 1: input register
  value_t            v1_q, lo1_q, hi1_q, f0_1_q, f1_1_q, bv1_q;
  logic              byp1_q;
  logic [SIDE_W-1:0] side1_q;

  always_ff @(posedge clk_i) begin
    v1_q    <= v_i;
    lo1_q   <= lo_i;
    hi1_q   <= hi_i;
    f0_1_q  <= f0_i;
    f1_1_q  <= f1_i;
    byp1_q  <= byp_i;
    bv1_q   <= byp_val_i;
    side1_q <= side_i;
  end

  // stage 2: differences and cell ends
  logic signed [MAG_W-1:0] diff2_q, span2_q;
  value_t                  v2_q, lo2_q, mn2_q, mx2_q;
  ctx_t                    ctx2_q;

  always_ff @(posedge clk_i) begin
    diff2_q     <= $signed({f1_1_q[VALUE_W-1], f1_1_q}) - $signed({f0_1_q[VALUE_W-1], f0_1_q});
    span2_q     <= $signed({hi1_q[VALUE_W-1], hi1_q}) - $signed({lo1_q[VALUE_W-1], lo1_q});
    mn2_q       <= (lo1_q < hi1_q) ? lo1_q : hi1_q;
    mx2_q       <= (lo1_q < hi1_q) ? hi1_q : lo1_q;
    v2_q        <= v1_q;
    lo2_q       <= lo1_q;
    ctx2_q.f0   <= f0_1_q;
    ctx2_q.dneg <= 1'b0;
    ctx2_q.zero <= hi1_q == lo1_q;
    ctx2_q.byp  <= byp1_q;
    ctx2_q.bval <= bv1_q;
    ctx2_q.side <= side1_q;
    ctx2_q.dmag <= '0;
  end

  // stage 3: keep the coordinate inside its cell
  logic signed [MAG_W-1:0] diff3_q, span3_q;
  value_t                  vc3_q, lo3_q;
  ctx_t                    ctx3_q;

  always_ff @(posedge clk_i) begin
    vc3_q   <= (v2_q < mn2_q) ? mn2_q : ((v2_q > mx2_q) ? mx2_q : v2_q);
    diff3_q <= diff2_q;
    span3_q <= span2_q;
    lo3_q   <= lo2_q;
    ctx3_q  <= ctx2_q;
  end

  // stage 4: offset and magnitudes
  logic signed [MAG_W-1:0] off4_q;
  logic [MAG_W-1:0]        smag4_q;
  ctx_t                    ctx4_q;

  always_ff @(posedge clk_i) begin
    off4_q      <= $signed({vc3_q[VALUE_W-1], vc3_q}) - $signed({lo3_q[VALUE_W-1], lo3_q});
    smag4_q     <= span3_q[MAG_W-1] ? MAG_W'(-span3_q) : MAG_W'(span3_q);
    ctx4_q      <= ctx3_q;
    ctx4_q.dneg <= diff3_q[MAG_W-1];
    ctx4_q.dmag <= diff3_q[MAG_W-1] ? MAG_W'(-diff3_q) : MAG_W'(diff3_q);
  end

  logic [MAG_W-1:0] omag5_q, smag5_q;
  ctx_t             ctx5_q;

  always_ff @(posedge clk_i) begin
    omag5_q <= off4_q[MAG_W-1] ? MAG_W'(-off4_q) : MAG_W'(off4_q);
    smag5_q <= smag4_q;
    ctx5_q  <= ctx4_q;
  end

  // stage 6 is the product, then one quotient bit per stage
  logic [PROD_W-1:0] w_q   [DIV_STEPS+1];
  logic [MAG_W-1:0]  d_q   [DIV_STEPS+1];
  ctx_t              ctx_q [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    w_q[0]   <= ctx5_q.dmag * omag5_q;
    d_q[0]   <= smag5_q;
    ctx_q[0] <= ctx5_q;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      w_q[k+1]   <= div_step(w_q[k], d_q[k]);
      d_q[k+1]   <= d_q[k];
      ctx_q[k+1] <= ctx_q[k];
    end
  end

  logic [MAG_W-1:0] quo, f0x, sum;
  value_t           res_q;
  logic [SIDE_W-1:0] side_q;

  assign quo = w_q[DIV_STEPS][MAG_W-1:0];
  assign f0x = {ctx_q[DIV_STEPS].f0[VALUE_W-1], ctx_q[DIV_STEPS].f0};
  assign sum = ctx_q[DIV_STEPS].dneg ? f0x - quo : f0x + quo;

  always_ff @(posedge clk_i) begin
    if (ctx_q[DIV_STEPS].byp) res_q <= ctx_q[DIV_STEPS].bval;
    else if (ctx_q[DIV_STEPS].zero) res_q <= ctx_q[DIV_STEPS].f0;
    else res_q <= value_t'(sum[VALUE_W-1:0]);
    side_q <= ctx_q[DIV_STEPS].side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NVLD-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[NVLD-1];
  assign res_o       = res_q;
  assign side_o      = side_q;

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NVLD-2] && (d_q[DIV_STEPS] != '0))
      |-> (w_q[DIV_STEPS][PROD_W-1:MAG_W] < d_q[DIV_STEPS]))
    else $error("divider remainder not below divisor");

  a_quo_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NVLD-2] && !ctx_q[DIV_STEPS].zero) |-> (quo <= ctx_q[DIV_STEPS].dmag))
    else $error("step exceeds the corner difference");
`endif

endmodule

>>> src/table_bilinear_interpolator.sv
// Bilinear lookup in a two-axis table of signed Q16.16 values.
// Input words arrive on start_i and are taken at any edge with start_i high;
// busy_o stays low, so one word can be taken every cycle. op_i selects a write
// of the density axis, the temperature axis or the grid, or a query.
// Writes give no result. A query gives one result word on result_valid_o,
// high for a single cycle, after axis search and table read (compare,
// two-level count tree, banked read) and then the interpolation steps
// in turn, density on both rows then temperature, each pipeline with a
// divider that gives one quotient bit per stage.
// Results leave in the order the queries arrived, one per cycle at most.
// Counts are written on the cfg channel (index 0 density count, 1 temperature
// count), always ready; write them while no query is in flight.
// Reset clears the pipeline valid bits and sets both counts to 64; axis and
// grid contents are undefined until written. The receiver cannot stall.
// depends on tbi_pkg, tbi_axis, tbi_grid, tbi_lerp
module table_bilinear_interpolator import tbi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [IDX_W-1:0]      rho_index_i,
  input  logic [IDX_W-1:0]      temp_index_i,
  input  logic signed [VALUE_W-1:0] table_value_i,
  input  logic signed [VALUE_W-1:0] rho_query_i,
  input  logic signed [VALUE_W-1:0] temp_query_i,
  input  logic                  last_query_i,
  output logic                  result_valid_o,
  output logic signed [VALUE_W-1:0] emission_o,
  output logic                  rho_clamped_o,
  output logic                  temp_clamped_o,
  output logic                  last_result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef struct packed {
    value_t rq;
    value_t tq;
    logic   last;
  } qside_t;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic [CNT_REG_W-1:0] rho_cnt_q, temp_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho_cnt_q  <= COUNT_RESET;
      temp_cnt_q <= COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_RHO_COUNT)  rho_cnt_q  <= cfg_data_i[CNT_REG_W-1:0];
      if (cfg_index_i == CFG_TEMP_COUNT) temp_cnt_q <= cfg_data_i[CNT_REG_W-1:0];
    end
  end

  // stage 1: input word register
  logic             vld1_q;
  op_e              op1_q;
  logic [IDX_W-1:0] ri1_q, ti1_q;
  value_t           val1_q;
  qside_t           qs1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld1_q <= 1'b0;
    else vld1_q <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= op_e'(op_i);
    ri1_q   <= rho_index_i;
    ti1_q   <= temp_index_i;
    val1_q  <= table_value_i;
    qs1_q.rq   <= rho_query_i;
    qs1_q.tq   <= temp_query_i;
    qs1_q.last <= last_query_i;
  end

  logic     qv1;
  tbl_wr_t  rho_wr, temp_wr;
  grid_wr_t grid_wr;

  assign qv1 = vld1_q && (op1_q == OP_QUERY);

  always_comb begin
    rho_wr.en    = vld1_q && (op1_q == OP_WR_RHO);
    rho_wr.idx   = ri1_q;
    rho_wr.val   = val1_q;
    temp_wr.en   = vld1_q && (op1_q == OP_WR_TEMP);
    temp_wr.idx  = ti1_q;
    temp_wr.val  = val1_q;
    grid_wr.en   = vld1_q && (op1_q == OP_WR_GRID);
    grid_wr.row  = ti1_q;
    grid_wr.col  = ri1_q;
    grid_wr.val  = val1_q;
  end

  // query fields ride along to the table read, grid writes to its address stage
  logic     qv_q [5];
  qside_t   qd_q [5];
  grid_wr_t gw_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) qv_q[k] <= 1'b0;
      for (int k = 0; k < 4; k++) gw_q[k] <= '0;
    end else begin
      qv_q[0] <= qv1;
      for (int k = 1; k < 5; k++) qv_q[k] <= qv_q[k-1];
      gw_q[0] <= grid_wr;
      for (int k = 1; k < 4; k++) gw_q[k] <= gw_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    qd_q[0] <= qs1_q;
    for (int k = 1; k < 5; k++) qd_q[k] <= qd_q[k-1];
  end

  logic [IDX_W-1:0] rho_cell, temp_cell;
  axis_rd_t         rho_rd, temp_rd;
  grid_rd_t         corners;

  tbi_axis u_rho_axis (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qv1),
    .q_i       (qs1_q.rq),
    .count_i   (eff_count(rho_cnt_q)),
    .wr_i      (rho_wr),
    .cell_o    (rho_cell),
    .rd_o      (rho_rd)
  );

  tbi_axis u_temp_axis (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qv1),
    .q_i       (qs1_q.tq),
    .count_i   (eff_count(temp_cnt_q)),
    .wr_i      (temp_wr),
    .cell_o    (temp_cell),
    .rd_o      (temp_rd)
  );

  tbi_grid u_grid (
    .clk_i   (clk_i),
    .wr_i    (gw_q[3]),
    .rd_en_i (qv_q[3]),
    .row_i   (temp_cell),
    .col_i   (rho_cell),
    .rd_o    (corners)
  );

  // density step on both bracket rows
  row_side_t rside, rs0;
  logic      row0_valid;
  value_t    row0_res, row1_res;
  logic [SIDE_W-1:0] side0;

  always_comb begin
    rside.tq   = qd_q[4].tq;
    rside.tlo  = temp_rd.lo_val;
    rside.thi  = temp_rd.hi_val;
    rside.to   = temp_rd.clamped;
    rside.tsel = temp_rd.sel_hi;
    rside.ro   = rho_rd.clamped;
    rside.last = qd_q[4].last;
  end

  tbi_lerp u_row0 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qv_q[4]),
    .v_i         (qd_q[4].rq),
    .lo_i        (rho_rd.lo_val),
    .hi_i        (rho_rd.hi_val),
    .f0_i        (corners.g00),
    .f1_i        (corners.g01),
    .byp_i       (rho_rd.clamped),
    .byp_val_i   (rho_rd.sel_hi ? corners.g01 : corners.g00),
    .side_i      (rside),
    .out_valid_o (row0_valid),
    .res_o       (row0_res),
    .side_o      (side0)
  );

  tbi_lerp u_row1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qv_q[4]),
    .v_i         (qd_q[4].rq),
    .lo_i        (rho_rd.lo_val),
    .hi_i        (rho_rd.hi_val),
    .f0_i        (corners.g10),
    .f1_i        (corners.g11),
    .byp_i       (rho_rd.clamped),
    .byp_val_i   (rho_rd.sel_hi ? corners.g11 : corners.g10),
    .side_i      (rside),
    .out_valid_o (),
    .res_o       (row1_res),
    .side_o      ()
  );

  // temperature step between the two row results
  res_side_t tside, oside;
  logic [SIDE_W-1:0] side_out;

  assign rs0 = row_side_t'(side0);

  always_comb begin
    tside.pad  = '0;
    tside.ro   = rs0.ro;
    tside.to   = rs0.to;
    tside.last = rs0.last;
  end

  tbi_lerp u_temp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (row0_valid),
    .v_i         (rs0.tq),
    .lo_i        (rs0.tlo),
    .hi_i        (rs0.thi),
    .f0_i        (row0_res),
    .f1_i        (row1_res),
    .byp_i       (rs0.to),
    .byp_val_i   (rs0.tsel ? row1_res : row0_res),
    .side_i      (tside),
    .out_valid_o (result_valid_o),
    .res_o       (emission_o),
    .side_o      (side_out)
  );

  assign oside          = res_side_t'(side_out);
  assign rho_clamped_o  = oside.ro;
  assign temp_clamped_o = oside.to;
  assign last_result_o  = oside.last;

endmodule

>>> tb/tb_table_bilinear_interpolator.sv
// self-checking testbench of the table bilinear interpolator
// keeps its own copy of the axes, grid and counts, predicts each untyped query and
// compares each result word field by field; depends on tbi_pkg and the block's rtl
module tb_table_bilinear_interpolator;
  import tbi_pkg::*;

  typedef struct {
    op_e         op;
    logic [5:0]  ri;
    logic [5:0]  ti;
    logic [31:0] val;
    logic [31:0] rq;
    logic [31:0] tq;
    logic        last;
  } word_t;

  typedef struct {
    logic [31:0] em;
    logic        rc;
    logic        tc;
    logic        last;
  } lookup_t;

  typedef struct {
    word_t   w;
    logic    typed;
    lookup_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [OP_W-1:0] op_i = '0;
  logic [IDX_W-1:0] rho_index_i = '0;
  logic [IDX_W-1:0] temp_index_i = '0;
  logic signed [VALUE_W-1:0] table_value_i = '0;
  logic signed [VALUE_W-1:0] rho_query_i = '0;
  logic signed [VALUE_W-1:0] temp_query_i = '0;
  logic last_query_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic busy_o, result_valid_o, rho_clamped_o, temp_clamped_o, last_result_o, cfg_ready_o;
  logic signed [VALUE_W-1:0] emission_o;

  // mirrored block state
  logic signed [31:0] rho_tab [64];
  logic signed [31:0] temp_tab [64];
  logic signed [31:0] grid_tab [64][64];
  logic [6:0] rho_cnt = 7'd64;
  logic [6:0] temp_cnt = 7'd64;

  lookup_t lookup_q [$];
  bit failed = 1'b0;
  bit no_idle = 1'b0;

  table_bilinear_interpolator i_dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic int eff_cnt(logic [6:0] c);
    if (c < 7'd2) return 2;
    if (c > 7'd64) return 64;
    return int'(c);
  endfunction

  function automatic longint axis_at(bit use_rho, int i);
    return use_rho ? longint'(rho_tab[i]) : longint'(temp_tab[i]);
  endfunction

  function automatic logic [63:0] magn(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint lerp_step(longint v, longint lo, longint hi, longint f0,
                                       longint f1);
    longint mn, mx, diff;
    logic [63:0] q;
    if (hi == lo) return f0;
    mn = lo < hi ? lo : hi;
    mx = lo < hi ? hi : lo;
    if (v < mn) v = mn;
    if (v > mx) v = mx;
    diff = f1 - f0;
    q = (magn(diff) * magn(v - lo)) / magn(hi - lo);
    return diff < 0 ? f0 - longint'(q) : f0 + longint'(q);
  endfunction

  // bracket search: lower cell index, outside flag and nearer end
  function automatic void find_cell(input bit use_rho, input int n, input longint v,
                                    output int lo, output bit outside, output int end_i);
    bit inc;
    inc = axis_at(use_rho, 1) >= axis_at(use_rho, 0);
    if (inc) begin
      outside = v < axis_at(use_rho, 0) || v > axis_at(use_rho, n - 1);
      end_i = v < axis_at(use_rho, 0) ? 0 : n - 1;
    end else begin
      outside = v > axis_at(use_rho, 0) || v < axis_at(use_rho, n - 1);
      end_i = v > axis_at(use_rho, 0) ? 0 : n - 1;
    end
    lo = 0;
    for (int i = 1; i + 1 < n; i++)
      if (inc ? axis_at(use_rho, i) < v : axis_at(use_rho, i) >= v) lo++;
  endfunction

  function automatic lookup_t interpolate(word_t w);
    lookup_t r;
    longint rq, tq, f0, f1, res;
    int rl, tl, re, te;
    bit ro, tout;
    rq = longint'($signed(w.rq));
    tq = longint'($signed(w.tq));
    find_cell(1'b1, eff_cnt(rho_cnt), rq, rl, ro, re);
    find_cell(1'b0, eff_cnt(temp_cnt), tq, tl, tout, te);
    if (!ro && !tout) begin
      f0 = lerp_step(rq, rho_tab[rl], rho_tab[rl+1], grid_tab[tl][rl], grid_tab[tl][rl+1]);
      f1 = lerp_step(rq, rho_tab[rl], rho_tab[rl+1], grid_tab[tl+1][rl],
                     grid_tab[tl+1][rl+1]);
      res = lerp_step(tq, temp_tab[tl], temp_tab[tl+1], f0, f1);
    end else if (ro && !tout) begin
      res = lerp_step(tq, temp_tab[tl], temp_tab[tl+1], grid_tab[tl][re], grid_tab[tl+1][re]);
    end else if (!ro && tout) begin
      res = lerp_step(rq, rho_tab[rl], rho_tab[rl+1], grid_tab[te][rl], grid_tab[te][rl+1]);
    end else begin
      res = grid_tab[te][re];
    end
    r.em = res[31:0];
    r.rc = ro;
    r.tc = tout;
    r.last = w.last;
    return r;
  endfunction

  // sends one word; called and returning at a rising edge
  task automatic send_word(word_t w, logic typed = 1'b0, lookup_t typed_res = '{default: 0});
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= w.op;
    rho_index_i <= w.ri;
    temp_index_i <= w.ti;
    table_value_i <= w.val;
    rho_query_i <= w.rq;
    temp_query_i <= w.tq;
    last_query_i <= w.last;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    case (w.op)
      OP_WR_RHO: rho_tab[w.ri] = w.val;
      OP_WR_TEMP: temp_tab[w.ti] = w.val;
      OP_WR_GRID: grid_tab[w.ti][w.ri] = w.val;
      OP_QUERY: lookup_q.push_back(typed ? typed_res : interpolate(w));
    endcase
  endtask

  // stop sending and let every query and write in flight finish
  task automatic drain();
    start_i <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [6:0] cnt);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= {$urandom_range(0, 1) ? 25'($urandom) : 25'd0, cnt};
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    if (idx == CFG_RHO_COUNT) rho_cnt = cnt;
    else temp_cnt = cnt;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic word_t mk(op_e op, int ri, int ti, logic [31:0] val);
    word_t w;
    w = '{op, 6'(ri), 6'(ti), val, $urandom, $urandom, 1'($urandom)};
    return w;
  endfunction

  function automatic word_t mk_query(logic [31:0] rq, logic [31:0] tq, logic last);
    word_t w;
    w = '{OP_QUERY, 6'($urandom), 6'($urandom), $urandom, rq, tq, last};
    return w;
  endfunction

  // rewrite one axis as a monotone run with random start, steps and direction
  task automatic load_axis(op_e op);
    longint v, step;
    bit down;
    down = $urandom_range(0, 1);
    v = longint'($signed(32'($urandom_range(0, 32'h7fff_ffff)))) - 64'sh4000_0000;
    for (int i = 0; i < 64; i++) begin
      send_word(mk(op, i, i, v[31:0]));
      step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << $urandom_range(4, 24));
      v = down ? v - step : v + step;
    end
  endtask

  function automatic logic [31:0] pick_coord(bit use_rho, int n);
    int k;
    longint a, b, mn;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'(axis_at(use_rho, $urandom_range(0, n - 1)));
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: begin
        k = $urandom_range(0, n - 2);
        a = axis_at(use_rho, k);
        b = axis_at(use_rho, k + 1);
        mn = a < b ? a : b;
        return 32'(mn + longint'($urandom) % (magn(a - b) + 1));
      end
    endcase
  endfunction

  always @(negedge clk_i) begin
    lookup_t e;
    if (rst_ni && result_valid_o) begin
      if (lookup_q.size() == 0) begin
        $error("result word with no query outstanding");
        failed = 1'b1;
      end else begin
        e = lookup_q.pop_front();
        if (emission_o !== e.em) begin
          $error("emission: expected %h, got %h", e.em, emission_o);
          failed = 1'b1;
        end
        if (rho_clamped_o !== e.rc) begin
          $error("rho_clamped: expected %b, got %b", e.rc, rho_clamped_o);
          failed = 1'b1;
        end
        if (temp_clamped_o !== e.tc) begin
          $error("temp_clamped: expected %b, got %b", e.tc, temp_clamped_o);
          failed = 1'b1;
        end
        if (last_result_o !== e.last) begin
          $error("last_result: expected %b, got %b", e.last, last_result_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    dir_row_t dir_tab [11];
    word_t w;
    int nr, nt;
    logic [6:0] cnt_list [7] = '{7'd2, 7'd64, 7'd0, 7'd1, 7'd65, 7'd127, 7'd9};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry written once so no query ever reads an unwritten one
    no_idle = 1'b1;
    for (int i = 0; i < 64; i++) begin
      send_word(mk(OP_WR_RHO, i, i, 32'(i) << 16));
      send_word(mk(OP_WR_TEMP, i, i, 32'(100 - i) << 16));
    end
    for (int t = 0; t < 64; t++)
      for (int r = 0; r < 64; r++) send_word(mk(OP_WR_GRID, r, t, 32'(t * 64 + r) << 8));
    no_idle = 1'b0;

    // rho axis 0..63, temp axis 100 down to 37, grid (row*64+col)<<8
    dir_tab = '{
      '{'{OP_QUERY, 6'd0, 6'd0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 1'b1}, 1'b1,
        '{32'h0, 1'b1, 1'b1, 1'b1}},
      '{'{OP_QUERY, 6'd63, 6'd63, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0}, 1'b1,
        '{32'h000f_ff00, 1'b1, 1'b1, 1'b0}},
      '{'{OP_WR_GRID, 6'd0, 6'd0, 32'h7fff_ffff, 32'h0, 32'h0, 1'b0}, 1'b0, '{default: 0}},
      '{'{OP_WR_GRID, 6'd1, 6'd0, 32'h8000_0000, 32'h0, 32'h0, 1'b0}, 1'b0, '{default: 0}},
      '{'{OP_QUERY, 6'd0, 6'd0, 32'h0, 32'h0000_8000, 32'h7fff_ffff, 1'b1}, 1'b0,
        '{default: 0}},
      '{'{OP_QUERY, 6'd0, 6'd0, 32'h0, 32'h003f_0000, 32'h0025_4000, 1'b0}, 1'b0,
        '{default: 0}},
      '{'{OP_QUERY, 6'd0, 6'd0, 32'h0, 32'h0, 32'h0064_0000, 1'b1}, 1'b0, '{default: 0}},
      // zero-width density cell
      '{'{OP_WR_RHO, 6'd5, 6'd0, 32'h0004_0000, 32'h0, 32'h0, 1'b0}, 1'b0, '{default: 0}},
      '{'{OP_QUERY, 6'd0, 6'd0, 32'h0, 32'h0004_0000, 32'h0050_8000, 1'b0}, 1'b0,
        '{default: 0}},
      // temperature axis made unordered
      '{'{OP_WR_TEMP, 6'd0, 6'd10, 32'h00c8_0000, 32'h0, 32'h0, 1'b0}, 1'b0, '{default: 0}},
      '{'{OP_QUERY, 6'd0, 6'd0, 32'h0, 32'h0020_1234, 32'h005a_8000, 1'b1}, 1'b0,
        '{default: 0}}
    };
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res);

    // phases: counts change only with nothing in flight
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      cfg_write(CFG_RHO_COUNT, cnt_list[ph]);
      cfg_write(CFG_TEMP_COUNT, ph == 6 ? 7'($urandom_range(2, 64)) : cnt_list[6 - ph]);
      no_idle = (ph == 3);
      load_axis(OP_WR_RHO);
      load_axis(OP_WR_TEMP);
      nr = eff_cnt(rho_cnt);
      nt = eff_cnt(temp_cnt);
      for (int n = 0; n < 70; n++) begin
        case ($urandom_range(0, 9))
          0: w = mk(OP_WR_GRID, $urandom, $urandom,
                    $urandom_range(0, 3) == 0 ? 32'h8000_0000 : $urandom);
          1: w = mk(OP_WR_GRID, $urandom_range(0, nr - 1), $urandom_range(0, nt - 1), $urandom);
          2: w = mk($urandom_range(0, 1) ? OP_WR_RHO : OP_WR_TEMP, $urandom, $urandom,
                    $urandom);
          default: w = mk_query(pick_coord(1'b1, nr), pick_coord(1'b0, nt), 1'($urandom));
        endcase
        send_word(w);
      end
    end

    drain();
    if (!failed) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
